// ===== sv/msb_first_bit_field_store_defines.svh =====
// ============================================================================
// msb_first_bit_field_store_defines.svh
// Assertion macros for the MSB-first bit field store.
// ============================================================================
`ifndef MSB_FIRST_BIT_FIELD_STORE_DEFINES_SVH
`define MSB_FIRST_BIT_FIELD_STORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checked on every rising clock edge outside reset.
`define MSBFS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked on every rising clock edge, reset included.
`define MSBFS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MSBFS_ASSERT(lbl, prop, msg)
`define MSBFS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== sv/msbfs_pkg.sv =====
// ============================================================================
// msbfs_pkg
// Types and constants shared by the MSB-first bit field store.
// ============================================================================
package msbfs_pkg;

    // Field widths of the stream items.
    localparam int unsigned POS_W  = 15;
    localparam int unsigned CODE_W = 32;
    localparam int unsigned LEN_W  = 6;
    localparam int unsigned NEXT_W = 16;

    // Store geometry and field limits.
    localparam int unsigned STORE_BYTES_DEF = 4096;
    localparam int unsigned MAX_FIELD_BITS  = 32;
    localparam int unsigned BYTE_W          = 8;

    // A field of the longest length at the worst offset spans this many bytes.
    localparam int unsigned WIN_BYTES = (MAX_FIELD_BITS + 7 + 7) / 8;
    localparam int unsigned WIN_BITS  = WIN_BYTES * BYTE_W;

    // Item kinds carried in tuser.
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } opcode_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_WR_FETCH,
        ST_WR,
        ST_RD,
        ST_RD_LAST,
        ST_FINISH
    } state_t;

endpackage

// ===== sv/msbfs_ram.sv =====
// ============================================================================
// msbfs_ram
// Single-port synchronous RAM with a registered read port.
// ============================================================================
module msbfs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write when enabled; the registered read returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[addr] <= wdata;
        end
        rdata_reg <= mem_array[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/msb_first_bit_field_store.sv =====
// ============================================================================
// msb_first_bit_field_store
// Byte-addressed store of MSB-first packed bit fields of 1 to 32 bits.
// ============================================================================
// Usage: one input stream (s_*) carries write and read items; tuser is the
// opcode (0 writes, 1 reads). One output stream (m_*) returns one result item
// per input item: the position after the field and, for reads, the field.
// The block works on one item at a time. A field spans 1 to 5 bytes; an
// unaligned write first reads back the partly filled first byte. The next
// item is taken after the result is loaded. A zero-length item goes straight
// to its result. The order is set by the single port of the byte RAM, which
// is touched once per cycle, one byte at a time.
// A result sits in an output register, so the next item is accepted while a
// result still waits for m_tready; a result that cannot leave holds the
// sequencer until the register frees up.
// Reset clears the sequencer and the output valid only. The byte RAM is not
// cleared: a byte must be written before it is read. Byte addresses wrap
// modulo STORE_BYTES, which need not be a power of two.
// ============================================================================
`include "msb_first_bit_field_store_defines.svh"

module msb_first_bit_field_store
    import msbfs_pkg::*;
#(
    parameter int unsigned STORE_BYTES = STORE_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [14:0] bit_position, [46:15] code_value, [52:47] field_length, [55:53] zero
    input  logic [55:0] s_tdata,
    // [0] opcode
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] next_position, [47:16] read_value
    output logic [47:0] m_tdata
);

    localparam int unsigned AW      = $clog2(STORE_BYTES);
    localparam int unsigned ADDR0_W = POS_W - 3;
    localparam int unsigned SW      = $clog2(STORE_BYTES + 1);
    localparam int unsigned REM_W   = ADDR0_W + SW;
    localparam int unsigned SHW     = $clog2(WIN_BITS + 1);
    localparam int unsigned CNT_W   = $clog2(WIN_BYTES + 1);
    // Reciprocal of the store size, scaled by the range of a start byte address.
    localparam int unsigned RECIP   = (1 << ADDR0_W) / STORE_BYTES;
    localparam logic [ADDR0_W:0] RECIP_C     = (ADDR0_W + 1)'(RECIP);
    localparam logic [REM_W-1:0] STORE_C     = REM_W'(STORE_BYTES);
    localparam logic [AW-1:0]    LAST_ADDR   = AW'(STORE_BYTES - 1);
    localparam logic [LEN_W-1:0] MAX_LEN_C   = LEN_W'(MAX_FIELD_BITS);

    state_t state_reg, state_next;

    opcode_t               op_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [CODE_W-1:0]     val_reg;
    logic [ADDR0_W-1:0]    quot_reg;
    logic [AW-1:0]         addr_reg;
    logic [WIN_BITS-1:0]   win_reg;
    logic [WIN_BITS-1:0]   acc_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [2:0]            trail_reg;
    logic                  merge_reg;
    logic                  rd_pend_reg;
    logic [CODE_W-1:0]     res_reg;
    logic                  m_tvalid_reg;
    logic [NEXT_W-1:0]     out_pos_reg;
    logic [CODE_W-1:0]     out_val_reg;

    logic                  in_accept;
    logic                  out_load;
    logic                  mem_we;
    logic                  mem_access;
    logic [BYTE_W-1:0]     mem_wdata;
    logic [BYTE_W-1:0]     mem_rdata;

    // Unpacked input fields.
    logic [POS_W-1:0]      in_pos;
    logic [CODE_W-1:0]     in_code;
    logic [LEN_W-1:0]      in_len;
    logic [LEN_W-1:0]      in_len_eff;
    logic [CODE_W:0]       in_mask;
    logic [2*ADDR0_W:0]    in_prod;

    // Setup arithmetic.
    logic [2:0]            off;
    logic [LEN_W-1:0]      off_len;
    logic [REM_W-1:0]      rem_raw;
    logic [REM_W-1:0]      rem_fix;
    logic [SHW-1:0]        win_sh;
    logic [WIN_BITS-1:0]   acc_fin;
    logic [WIN_BITS-1:0]   acc_sh;
    logic [CODE_W:0]       len_mask;
    logic [AW-1:0]         addr_inc;

    assign in_pos  = s_tdata[14:0];
    assign in_code = s_tdata[46:15];
    assign in_len  = s_tdata[52:47];

    assign in_accept = s_tvalid && s_tready;

    // Saturate the length and drop code bits above it.
    always_comb
    begin
        in_len_eff = (in_len > MAX_LEN_C) ? MAX_LEN_C : in_len;
        in_mask    = ((CODE_W + 1)'(1) << in_len_eff) - (CODE_W + 1)'(1);
        in_prod    = (2 * ADDR0_W + 1)'(in_pos[POS_W-1:3]) * (2 * ADDR0_W + 1)'(RECIP_C);
    end

    // Start address modulo the store size: the quotient estimate is low by at
    // most one, so one compare and subtract finishes the remainder.
    always_comb
    begin
        off      = pos_reg[2:0];
        off_len  = LEN_W'(off) + len_reg;
        rem_raw  = REM_W'(pos_reg[POS_W-1:3]) - REM_W'(quot_reg) * STORE_C;
        rem_fix  = (rem_raw >= STORE_C) ? (rem_raw - STORE_C) : rem_raw;
        win_sh   = SHW'(WIN_BITS) - SHW'(off_len);
        addr_inc = (addr_reg == LAST_ADDR) ? '0 : (addr_reg + AW'(1));
    end

    // Final read assembly: drop trailing bits, keep the field.
    always_comb
    begin
        acc_fin  = {acc_reg[WIN_BITS-BYTE_W-1:0], mem_rdata};
        acc_sh   = acc_fin >> trail_reg;
        len_mask = ((CODE_W + 1)'(1) << len_reg) - (CODE_W + 1)'(1);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (len_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else if (op_reg == OP_READ)
                begin
                    state_next = ST_RD;
                end
                else if (off != 3'd0)
                begin
                    state_next = ST_WR_FETCH;
                end
                else
                begin
                    state_next = ST_WR;
                end
            end
            ST_WR_FETCH:
            begin
                state_next = ST_WR;
            end
            ST_WR:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_RD:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_RD_LAST;
                end
            end
            ST_RD_LAST:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        s_tready   = 1'b0;
        mem_we     = 1'b0;
        mem_access = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_WR_FETCH, ST_RD:
            begin
                mem_access = 1'b1;
            end
            ST_WR:
            begin
                mem_we     = 1'b1;
                mem_access = 1'b1;
            end
            ST_FINISH:
            begin
                out_load = !m_tvalid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // The first byte of an unaligned write keeps the bits already there.
    assign mem_wdata = merge_reg ? (mem_rdata | win_reg[WIN_BITS-1 -: BYTE_W])
                                 : win_reg[WIN_BITS-1 -: BYTE_W];

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            merge_reg    <= 1'b0;
            rd_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= (state_reg == ST_RD);
            case (state_reg)
                ST_SETUP:
                begin
                    cnt_reg   <= CNT_W'((off_len + LEN_W'(7)) >> 3);
                    merge_reg <= 1'b0;
                end
                ST_WR_FETCH:
                begin
                    merge_reg <= 1'b1;
                end
                ST_WR, ST_RD:
                begin
                    cnt_reg   <= cnt_reg - CNT_W'(1);
                    merge_reg <= 1'b0;
                end
                default:
                begin
                    merge_reg <= merge_reg;
                end
            endcase
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_reg   <= opcode_t'(s_tuser);
                    pos_reg  <= in_pos;
                    len_reg  <= in_len_eff;
                    val_reg  <= in_code & in_mask[CODE_W-1:0];
                    quot_reg <= in_prod[ADDR0_W +: ADDR0_W];
                end
            end
            ST_SETUP:
            begin
                addr_reg  <= rem_fix[AW-1:0];
                win_reg   <= WIN_BITS'(val_reg) << win_sh;
                acc_reg   <= '0;
                trail_reg <= 3'(-off_len);
                res_reg   <= '0;
            end
            ST_WR:
            begin
                win_reg  <= win_reg << BYTE_W;
                addr_reg <= addr_inc;
            end
            ST_RD:
            begin
                addr_reg <= addr_inc;
                if (rd_pend_reg)
                begin
                    acc_reg <= acc_fin;
                end
            end
            ST_RD_LAST:
            begin
                res_reg <= acc_sh[CODE_W-1:0] & len_mask[CODE_W-1:0];
            end
            default:
            begin
                addr_reg <= addr_reg;
            end
        endcase
        if (out_load)
        begin
            out_pos_reg <= NEXT_W'(pos_reg) + NEXT_W'(len_reg);
            out_val_reg <= res_reg;
        end
    end

    // Byte store.
    msbfs_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (addr_reg),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_val_reg, out_pos_reg};

    // Checks on the sequencer.
    `MSBFS_ASSERT(a_cnt_range, cnt_reg <= CNT_W'(WIN_BYTES), "byte count beyond window")
    `MSBFS_ASSERT(a_addr_range, mem_access |-> (32'(addr_reg) < STORE_BYTES), "address not wrapped")
    `MSBFS_ASSERT(a_merge_after_fetch, (state_reg == ST_WR && merge_reg) |-> $past(state_reg == ST_WR_FETCH), "merge without fetch")
    `MSBFS_ASSERT(a_result_from_finish, $rose(m_tvalid_reg) |-> $past(state_reg == ST_FINISH), "result outside finish")

endmodule
